### rtl/msc_pkg.sv
package msc_pkg;

    localparam int MEM_WORDS = 4096;
    localparam int MEM_AW    = $clog2(MEM_WORDS);

    localparam int CFG_W = 14;

    // actions (s_tuser)
    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_READ = 2'd1;
    localparam logic [1:0] ACT_EXEC = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_CODE_BASE = 2'd0;
    localparam logic [1:0] CFG_GP_RESET  = 2'd1;
    localparam logic [1:0] CFG_SP_RESET  = 2'd2;

    // status codes (m_tuser)
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EXIT     = 3'd1;
    localparam logic [2:0] ST_STACK_OV = 3'd2;
    localparam logic [2:0] ST_PRINT    = 3'd3;
    localparam logic [2:0] ST_UNK_SYS  = 3'd4;
    localparam logic [2:0] ST_DIV_ZERO = 3'd5;
    localparam logic [2:0] ST_HALTED   = 3'd6;

    localparam logic [13:0] CODE_BASE_RESET = 14'd12288;
    localparam logic [13:0] GP_RESET        = 14'd6144;
    localparam logic [13:0] SP_RESET        = 14'd16380;

    localparam logic [4:0] REG_GP = 5'd28;
    localparam logic [4:0] REG_SP = 5'd29;
    localparam logic [4:0] REG_V0 = 5'd2;
    localparam logic [4:0] REG_A0 = 5'd4;
    localparam logic [4:0] REG_RA = 5'd31;

    // opcodes
    localparam logic [5:0] OP_SPECIAL = 6'd0;
    localparam logic [5:0] OP_J       = 6'd2;
    localparam logic [5:0] OP_JAL     = 6'd3;
    localparam logic [5:0] OP_BEQ     = 6'd4;
    localparam logic [5:0] OP_BNE     = 6'd5;
    localparam logic [5:0] OP_ADDI    = 6'd8;
    localparam logic [5:0] OP_ADDIU   = 6'd9;
    localparam logic [5:0] OP_SLTI    = 6'd10;
    localparam logic [5:0] OP_ANDI    = 6'd12;
    localparam logic [5:0] OP_ORI     = 6'd13;
    localparam logic [5:0] OP_LUI     = 6'd15;
    localparam logic [5:0] OP_LB      = 6'd32;
    localparam logic [5:0] OP_LH      = 6'd33;
    localparam logic [5:0] OP_LW      = 6'd35;
    localparam logic [5:0] OP_SB      = 6'd40;
    localparam logic [5:0] OP_SH      = 6'd41;
    localparam logic [5:0] OP_SW      = 6'd43;

    // funct codes
    localparam logic [5:0] FN_SLL     = 6'd0;
    localparam logic [5:0] FN_SRL     = 6'd2;
    localparam logic [5:0] FN_SRA     = 6'd3;
    localparam logic [5:0] FN_JR      = 6'd8;
    localparam logic [5:0] FN_SYSCALL = 6'd12;
    localparam logic [5:0] FN_MFHI    = 6'd16;
    localparam logic [5:0] FN_MFLO    = 6'd18;
    localparam logic [5:0] FN_MULT    = 6'd24;
    localparam logic [5:0] FN_DIV     = 6'd26;
    localparam logic [5:0] FN_ADD     = 6'd32;
    localparam logic [5:0] FN_SUB     = 6'd34;
    localparam logic [5:0] FN_AND     = 6'd36;
    localparam logic [5:0] FN_OR      = 6'd37;
    localparam logic [5:0] FN_SLT     = 6'd42;

    // syscall codes
    localparam logic [31:0] SYS_PRINT_INT  = 32'd1;
    localparam logic [31:0] SYS_PRINT_STR  = 32'd4;
    localparam logic [31:0] SYS_PRINT_HEX  = 32'd34;
    localparam logic [31:0] SYS_PRINT_UNS  = 32'd36;
    localparam logic [31:0] SYS_EXIT       = 32'd10;

    // reset values that registers 28 and 29 fall back to
    typedef struct packed {
        logic [CFG_W-1:0] gp;
        logic [CFG_W-1:0] sp;
        logic             gp_kill;
        logic             sp_kill;
    } rf_dflt_t;

    function automatic logic [31:0] sext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [MEM_AW-1:0] idx_to_word(input logic [11:0] idx);
        logic [31:0] t;
        t = {20'd0, idx};
        return t[MEM_AW-1:0];
    endfunction

endpackage

### rtl/mips_subset_core.sv
// Execute steps: fetch issue, decode and register read, execute, response; loads and
// sb/sh add a memory step, and div waits on the 32-step divider.
// Items: one at a time; the single-port main memory and the register file read ports
// are used in sequence per instruction.
// Reset: asynchronous, active low; afterwards a clearing pass zeroes main memory with
// s_tready low. Configuration writes are taken throughout.
module mips_subset_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,   // word_index[11:0], load_data[43:12], zero pad
    input  logic [1:0]   s_tuser,   // action[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // next_pc, syscall_code, syscall_argument, read_data
    output logic [2:0]   m_tuser,   // status[2:0]
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [13:0]  cfg_data
);

    localparam int AW = msc_pkg::MEM_AW;

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b00000001,
        S_IDLE   = 8'b00000010,
        S_RDWAIT = 8'b00000100,
        S_FETCH  = 8'b00001000,
        S_EXEC   = 8'b00010000,
        S_MEM    = 8'b00100000,
        S_DIV    = 8'b01000000,
        S_RESP   = 8'b10000000
    } state_t;

    state_t state_reg, state_next;

    // configuration and architectural state
    logic [13:0] code_base_reg, gp_reg, sp_reg;
    logic [31:0] pc_reg, hi_reg, lo_reg;
    logic        halted_reg;
    logic [AW-1:0] clr_reg;

    // per-item result, held until the response transfer
    logic [2:0]  st_reg;
    logic [31:0] sc_code_reg, sc_arg_reg, rd_reg, ins_reg;
    logic [AW-1:0] w_reg;
    logic [1:0]  lane_reg;
    logic [31:0] b_hold_reg;

    // output register
    logic         out_valid_reg;
    logic [127:0] out_data_reg;
    logic [2:0]   out_user_reg;

    logic s_fire, cfg_fire;
    logic [1:0]  in_action;
    logic [11:0] in_index;
    logic [31:0] in_data;

    assign in_index  = s_tdata[11:0];
    assign in_data   = s_tdata[43:12];
    assign in_action = s_tuser;
    assign s_tready  = state_reg == S_IDLE;
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid;

    // main memory port
    logic          mem_en, mem_we;
    logic [AW-1:0] mem_addr;
    logic [31:0]   mem_wdata, mem_rdata;

    msc_mem u_mem (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // register file
    msc_pkg::rf_dflt_t rf_dflt;
    logic [4:0]  rf_ra, rf_rb, rf_wa;
    logic [31:0] rf_a, rf_b, rf_wd;
    logic        rf_we;

    assign rf_dflt.gp      = gp_reg;
    assign rf_dflt.sp      = sp_reg;
    assign rf_dflt.gp_kill = cfg_fire && cfg_index == msc_pkg::CFG_GP_RESET;
    assign rf_dflt.sp_kill = cfg_fire && cfg_index == msc_pkg::CFG_SP_RESET;

    msc_regfile u_rf (
        .clk     (clk),
        .rst_n   (rst_n),
        .dflt    (rf_dflt),
        .raddr_a (rf_ra),
        .raddr_b (rf_rb),
        .rdata_a (rf_a),
        .rdata_b (rf_b),
        .we      (rf_we),
        .waddr   (rf_wa),
        .wdata   (rf_wd)
    );

    // divider
    logic        div_start, div_done;
    logic [31:0] div_q, div_r;

    msc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rf_a),
        .divisor  (rf_b),
        .done     (div_done),
        .quot     (div_q),
        .rem      (div_r)
    );

    // decode of the fetched word (syscall reads v0 and a0 instead of rs/rt)
    logic [5:0] f_op, f_fn;
    assign f_op = mem_rdata[31:26];
    assign f_fn = mem_rdata[5:0];

    always_comb
    begin
        if (f_op == msc_pkg::OP_SPECIAL && f_fn == msc_pkg::FN_SYSCALL)
        begin
            rf_ra = msc_pkg::REG_V0;
            rf_rb = msc_pkg::REG_A0;
        end
        else
        begin
            rf_ra = mem_rdata[25:21];
            rf_rb = mem_rdata[20:16];
        end
    end

    // execute-stage fields
    logic [5:0]  op, fn;
    logic [4:0]  rt, rd, sh;
    logic [15:0] imm;
    logic [31:0] simm, pc4, eaddr, jtgt, btgt;
    logic signed [63:0] prod;

    assign op    = ins_reg[31:26];
    assign fn    = ins_reg[5:0];
    assign rt    = ins_reg[20:16];
    assign rd    = ins_reg[15:11];
    assign sh    = ins_reg[10:6];
    assign imm   = ins_reg[15:0];
    assign simm  = msc_pkg::sext16(imm);
    assign pc4   = pc_reg + 32'd4;
    assign eaddr = rf_a + simm;
    assign jtgt  = {pc4[31:28], ins_reg[25:0], 2'b00};
    assign btgt  = pc4 + {simm[29:0], 2'b00};
    assign prod  = $signed(rf_a) * $signed(rf_b);

    // execute-stage effects
    logic [31:0] ex_wd, ex_npc;
    logic [4:0]  ex_wa;
    logic        ex_we, ex_mult, ex_div, ex_mem, ex_sw, ex_halt;
    logic [2:0]  ex_st;
    logic        ex_sc_arg;

    always_comb
    begin
        ex_wd     = 32'd0;
        ex_wa     = rd;
        ex_we     = 1'b0;
        ex_npc    = pc4;
        ex_mult   = 1'b0;
        ex_div    = 1'b0;
        ex_mem    = 1'b0;
        ex_sw     = 1'b0;
        ex_halt   = 1'b0;
        ex_st     = msc_pkg::ST_OK;
        ex_sc_arg = 1'b0;
        case (op)
            msc_pkg::OP_SPECIAL:
            begin
                case (fn)
                    msc_pkg::FN_SLL: begin ex_we = 1'b1; ex_wd = rf_b << sh; end
                    msc_pkg::FN_SRL: begin ex_we = 1'b1; ex_wd = rf_b >> sh; end
                    msc_pkg::FN_SRA:
                    begin
                        ex_we = 1'b1;
                        ex_wd = $unsigned($signed(rf_b) >>> sh);
                    end
                    msc_pkg::FN_JR:   ex_npc = rf_a;
                    msc_pkg::FN_SYSCALL:
                    begin
                        if (rf_a == msc_pkg::SYS_PRINT_INT || rf_a == msc_pkg::SYS_PRINT_STR ||
                            rf_a == msc_pkg::SYS_PRINT_HEX || rf_a == msc_pkg::SYS_PRINT_UNS)
                        begin
                            ex_st     = msc_pkg::ST_PRINT;
                            ex_sc_arg = 1'b1;
                        end
                        else if (rf_a == msc_pkg::SYS_EXIT)
                        begin
                            ex_st   = msc_pkg::ST_EXIT;
                            ex_halt = 1'b1;
                        end
                        else
                            ex_st = msc_pkg::ST_UNK_SYS;
                    end
                    msc_pkg::FN_MFHI: begin ex_we = 1'b1; ex_wd = hi_reg; end
                    msc_pkg::FN_MFLO: begin ex_we = 1'b1; ex_wd = lo_reg; end
                    msc_pkg::FN_MULT: ex_mult = 1'b1;
                    msc_pkg::FN_DIV:
                    begin
                        if (rf_b == 32'd0)
                            ex_st = msc_pkg::ST_DIV_ZERO;
                        else
                            ex_div = 1'b1;
                    end
                    msc_pkg::FN_ADD: begin ex_we = 1'b1; ex_wd = rf_a + rf_b; end
                    msc_pkg::FN_SUB: begin ex_we = 1'b1; ex_wd = rf_a - rf_b; end
                    msc_pkg::FN_AND: begin ex_we = 1'b1; ex_wd = rf_a & rf_b; end
                    msc_pkg::FN_OR:  begin ex_we = 1'b1; ex_wd = rf_a | rf_b; end
                    msc_pkg::FN_SLT:
                    begin
                        ex_we = 1'b1;
                        ex_wd = {31'd0, $signed(rf_a) < $signed(rf_b)};
                    end
                    default: ;
                endcase
            end
            msc_pkg::OP_J:  ex_npc = jtgt;
            msc_pkg::OP_JAL:
            begin
                ex_npc = jtgt;
                ex_we  = 1'b1;
                ex_wa  = msc_pkg::REG_RA;
                ex_wd  = pc4;
                // jal to the code base or below counts as stack overflow
                if (jtgt <= {18'd0, code_base_reg})
                begin
                    ex_st   = msc_pkg::ST_STACK_OV;
                    ex_halt = 1'b1;
                end
            end
            msc_pkg::OP_BEQ: if (rf_a == rf_b) ex_npc = btgt;
            msc_pkg::OP_BNE: if (rf_a != rf_b) ex_npc = btgt;
            msc_pkg::OP_ADDI, msc_pkg::OP_ADDIU:
            begin
                ex_we = 1'b1; ex_wa = rt; ex_wd = rf_a + simm;
            end
            msc_pkg::OP_SLTI:
            begin
                ex_we = 1'b1; ex_wa = rt;
                ex_wd = {31'd0, $signed(rf_a) < $signed(simm)};
            end
            msc_pkg::OP_ANDI: begin ex_we = 1'b1; ex_wa = rt; ex_wd = rf_a & {16'd0, imm}; end
            msc_pkg::OP_ORI:  begin ex_we = 1'b1; ex_wa = rt; ex_wd = rf_a | {16'd0, imm}; end
            msc_pkg::OP_LUI:  begin ex_we = 1'b1; ex_wa = rt; ex_wd = {imm, 16'd0}; end
            msc_pkg::OP_LB, msc_pkg::OP_LH, msc_pkg::OP_LW,
            msc_pkg::OP_SB, msc_pkg::OP_SH: ex_mem = 1'b1;
            msc_pkg::OP_SW: ex_sw = 1'b1;
            default: ;
        endcase
    end

    // memory-stage load extract and store merge
    logic [31:0] ld_shift, ld_val, st_merge;
    logic [4:0]  lane_bits, half_bits;

    assign lane_bits = {lane_reg, 3'b000};
    assign half_bits = {lane_reg[1], 4'b0000};

    always_comb
    begin
        ld_val   = mem_rdata;
        st_merge = mem_rdata;
        ld_shift = mem_rdata >> lane_bits;
        case (op)
            msc_pkg::OP_LB: ld_val = {{24{ld_shift[7]}}, ld_shift[7:0]};
            msc_pkg::OP_LH:
            begin
                ld_shift = mem_rdata >> half_bits;
                ld_val   = msc_pkg::sext16(ld_shift[15:0]);
            end
            msc_pkg::OP_SB:
                st_merge = (mem_rdata & ~(32'h000000ff << lane_bits))
                         | ({24'd0, b_hold_reg[7:0]} << lane_bits);
            msc_pkg::OP_SH:
                st_merge = (mem_rdata & ~(32'h0000ffff << half_bits))
                         | ({16'd0, b_hold_reg[15:0]} << half_bits);
            default: ;
        endcase
    end

    logic is_load;
    assign is_load = op == msc_pkg::OP_LB || op == msc_pkg::OP_LH || op == msc_pkg::OP_LW;

    // memory and register file port steering
    always_comb
    begin
        mem_en    = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = clr_reg;
        mem_wdata = 32'd0;
        rf_we     = 1'b0;
        rf_wa     = ex_wa;
        rf_wd     = ex_wd;
        div_start = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                mem_en = 1'b1;
                mem_we = 1'b1;
            end
            S_IDLE:
            begin
                if (s_fire)
                begin
                    if (in_action == msc_pkg::ACT_LOAD)
                    begin
                        mem_en    = 1'b1;
                        mem_we    = 1'b1;
                        mem_addr  = msc_pkg::idx_to_word(in_index);
                        mem_wdata = in_data;
                    end
                    else if (in_action == msc_pkg::ACT_READ)
                    begin
                        mem_en   = 1'b1;
                        mem_addr = msc_pkg::idx_to_word(in_index);
                    end
                    else if (in_action == msc_pkg::ACT_EXEC && !halted_reg)
                    begin
                        mem_en   = 1'b1;
                        mem_addr = pc_reg[AW+1:2];
                    end
                end
            end
            S_EXEC:
            begin
                rf_we     = ex_we;
                div_start = ex_div;
                mem_addr  = eaddr[AW+1:2];
                mem_wdata = rf_b;
                mem_en    = ex_mem || ex_sw;
                mem_we    = ex_sw;
            end
            S_MEM:
            begin
                mem_addr  = w_reg;
                mem_wdata = st_merge;
                mem_en    = !is_load;
                mem_we    = !is_load;
                rf_we     = is_load;
                rf_wa     = rt;
                rf_wd     = ld_val;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:  if (&clr_reg) state_next = S_IDLE;
            S_IDLE:
            begin
                if (s_fire)
                begin
                    if (in_action == msc_pkg::ACT_READ)
                        state_next = S_RDWAIT;
                    else if (in_action == msc_pkg::ACT_EXEC && !halted_reg)
                        state_next = S_FETCH;
                    else
                        state_next = S_RESP;
                end
            end
            S_RDWAIT: state_next = S_RESP;
            S_FETCH:  state_next = S_EXEC;
            S_EXEC:
            begin
                if (ex_mem)
                    state_next = S_MEM;
                else if (ex_div)
                    state_next = S_DIV;
                else
                    state_next = S_RESP;
            end
            S_MEM:    state_next = S_RESP;
            S_DIV:    if (div_done) state_next = S_RESP;
            S_RESP:   if (!out_valid_reg || m_tready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            code_base_reg <= msc_pkg::CODE_BASE_RESET;
            gp_reg        <= msc_pkg::GP_RESET;
            sp_reg        <= msc_pkg::SP_RESET;
            pc_reg        <= {18'd0, msc_pkg::CODE_BASE_RESET};
            hi_reg        <= 32'd0;
            lo_reg        <= 32'd0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            if (cfg_fire)
            begin
                case (cfg_index)
                    msc_pkg::CFG_CODE_BASE:
                    begin
                        code_base_reg <= cfg_data;
                        pc_reg        <= {18'd0, cfg_data};
                    end
                    msc_pkg::CFG_GP_RESET: gp_reg <= cfg_data;
                    msc_pkg::CFG_SP_RESET: sp_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == S_EXEC)
            begin
                pc_reg <= ex_npc;
                if (ex_halt)
                    halted_reg <= 1'b1;
                if (ex_mult)
                begin
                    hi_reg <= prod[63:32];
                    lo_reg <= prod[31:0];
                end
            end
            if (state_reg == S_DIV && div_done)
            begin
                lo_reg <= div_q;
                hi_reg <= div_r;
            end
            if (m_tvalid && m_tready)
                out_valid_reg <= 1'b0;
            if (state_reg == S_RESP && (!out_valid_reg || m_tready))
                out_valid_reg <= 1'b1;
        end
    end

    // item payload
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            st_reg      <= (in_action == msc_pkg::ACT_EXEC && halted_reg) ?
                           msc_pkg::ST_HALTED : msc_pkg::ST_OK;
            sc_code_reg <= 32'd0;
            sc_arg_reg  <= 32'd0;
            rd_reg      <= 32'd0;
        end
        if (state_reg == S_RDWAIT)
            rd_reg <= mem_rdata;
        if (state_reg == S_FETCH)
            ins_reg <= mem_rdata;
        if (state_reg == S_EXEC)
        begin
            st_reg     <= ex_st;
            w_reg      <= eaddr[AW+1:2];
            lane_reg   <= eaddr[1:0];
            b_hold_reg <= rf_b;
            if (op == msc_pkg::OP_SPECIAL && fn == msc_pkg::FN_SYSCALL)
                sc_code_reg <= rf_a;
            if (ex_sc_arg)
                sc_arg_reg <= rf_b;
        end
        if (state_reg == S_RESP && (!out_valid_reg || m_tready))
        begin
            out_data_reg <= {rd_reg, sc_arg_reg, sc_code_reg, pc_reg};
            out_user_reg <= st_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

### rtl/msc_mem.sv
module msc_mem (
    input  logic                       clk,
    input  logic                       en,
    input  logic                       we,
    input  logic [msc_pkg::MEM_AW-1:0] addr,
    input  logic [31:0]                wdata,
    output logic [31:0]                rdata
);

    logic [31:0] mem [msc_pkg::MEM_WORDS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
                mem[addr] <= wdata;
            else
                rdata <= mem[addr];
        end
    end

endmodule

### rtl/msc_regfile.sv
module msc_regfile (
    input  logic              clk,
    input  logic              rst_n,
    input  msc_pkg::rf_dflt_t dflt,
    input  logic [4:0]        raddr_a,
    input  logic [4:0]        raddr_b,
    output logic [31:0]       rdata_a,
    output logic [31:0]       rdata_b,
    input  logic              we,
    input  logic [4:0]        waddr,
    input  logic [31:0]       wdata
);

    logic [31:0] ram [32];
    logic [31:0] valid_reg;
    logic [31:0] ram_a_reg, ram_b_reg, dflt_a_reg, dflt_b_reg;
    logic        hit_a_reg, hit_b_reg;

    function automatic logic [31:0] dflt_of(input logic [4:0] a, input msc_pkg::rf_dflt_t d);
        logic [31:0] r;
        r = 32'd0;
        if (a == msc_pkg::REG_GP)
            r = {18'd0, d.gp};
        else if (a == msc_pkg::REG_SP)
            r = {18'd0, d.sp};
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        if (we && waddr != 5'd0)
            ram[waddr] <= wdata;
        ram_a_reg  <= ram[raddr_a];
        ram_b_reg  <= ram[raddr_b];
        dflt_a_reg <= dflt_of(raddr_a, dflt);
        dflt_b_reg <= dflt_of(raddr_b, dflt);
    end

    // register zero is never marked valid; a config write re-exposes the reset value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 32'd0;
            hit_a_reg <= 1'b0;
            hit_b_reg <= 1'b0;
        end
        else
        begin
            if (we && waddr != 5'd0)
                valid_reg[waddr] <= 1'b1;
            if (dflt.gp_kill)
                valid_reg[msc_pkg::REG_GP] <= 1'b0;
            if (dflt.sp_kill)
                valid_reg[msc_pkg::REG_SP] <= 1'b0;
            hit_a_reg <= valid_reg[raddr_a];
            hit_b_reg <= valid_reg[raddr_b];
        end
    end

    assign rdata_a = hit_a_reg ? ram_a_reg : dflt_a_reg;
    assign rdata_b = hit_b_reg ? ram_b_reg : dflt_b_reg;

endmodule

### rtl/msc_div.sv
module msc_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quot,
    output logic [31:0] rem
);

    logic        run_reg, done_reg, neg_q_reg, neg_r_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] q_reg, r_reg, d_reg;
    logic [32:0] shifted, diff;

    assign shifted = {r_reg, q_reg[31]};
    assign diff    = shifted - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            done_reg <= run_reg && cnt_reg == 5'd31;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= 5'd0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                    run_reg <= 1'b0;
            end
        end
    end

    // restoring division on magnitudes, one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg     <= dividend[31] ? -dividend : dividend;
            d_reg     <= divisor[31] ? -divisor : divisor;
            r_reg     <= 32'd0;
            neg_q_reg <= dividend[31] ^ divisor[31];
            neg_r_reg <= dividend[31];
        end
        else if (run_reg)
        begin
            if (!diff[32])
            begin
                r_reg <= diff[31:0];
                q_reg <= {q_reg[30:0], 1'b1};
            end
            else
            begin
                r_reg <= shifted[31:0];
                q_reg <= {q_reg[30:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quot = neg_q_reg ? -q_reg : q_reg;
    assign rem  = neg_r_reg ? -r_reg : r_reg;

endmodule

### rtl/msc_checker.sv
module msc_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic [2:0]   m_tuser
);

    // stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // one item in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while busy");

    // read data only comes with an ok status
    a_rdata_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != msc_pkg::ST_OK |-> m_tdata[127:96] == 32'd0)
        else $error("read data with non-ok status");

    // print argument only with host print status
    a_arg_print: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != msc_pkg::ST_PRINT |-> m_tdata[95:64] == 32'd0)
        else $error("syscall argument without print status");

endmodule

bind mips_subset_core msc_checker u_msc_checker (.*);
